@@ hdl/pmsv_pkg.sv @@
// Shared types, constants and helpers for the particle motion sample unit.
package pmsv_pkg;

  localparam int NUM_OBS           = 3;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int Q_DEPTH_DEF       = 4;
  localparam int CW                = 34;
  localparam int CFG_W             = 48;
  localparam int CFG_IDX_W         = 3;

  localparam logic [15:0] RANGE_LIM_RST  = 16'd1280;
  localparam logic [15:0] VIEW_WIDTH_RST = 16'd16384;
  localparam logic [15:0] SIG_NEAR_RST   = 16'd1966;
  localparam logic [15:0] SIG_FAR_RST    = 16'd6554;
  localparam logic [15:0] SIG_HEAD_RST   = 16'd10923;
  localparam logic [31:0] R2_RST         = 32'd1638400;
  localparam logic [38:0] FAR_THR_RST    = 39'd132710400;

  // turns (2^-16) to radians Q2.30, scaled by 2^16
  localparam logic [32:0] K_RAD  = 33'd6746518852;
  // radians Q2.30 to turns, scaled by 2^46
  localparam logic [29:0] K_TURN = 30'd683565276;
  // gain-compensated unit vector
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBS_ONE   = 3'd0,
    CFG_OBS_TWO   = 3'd1,
    CFG_OBS_THREE = 3'd2,
    CFG_RANGE_LIM = 3'd3,
    CFG_VIEW_W    = 3'd4,
    CFG_SIG_NEAR  = 3'd5,
    CFG_SIG_FAR   = 3'd6,
    CFG_SIG_HEAD  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        hd;
  } obs_pose_t;

  typedef struct packed {
    obs_pose_t [NUM_OBS-1:0] obs;
    logic [15:0]             view_width;
    logic [15:0]             sig_near;
    logic [15:0]             sig_far;
    logic [15:0]             sig_head;
    logic [31:0]             r2;
    logic [38:0]             far_thr;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] noise_range;
    logic signed [15:0] noise_heading;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [15:0]        new_heading;
    logic               moved;
  } out_word_t;

  // front to back: old pose, proposed heading and step length
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        h;
    logic [15:0]        nhd;
    logic signed [32:0] r;
  } fwd_word_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        h;
    logic [15:0]        nhd;
    logic signed [33:0] rn;
  } rot_pl_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        h;
    logic [15:0]        nhd;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } mv_t;

  typedef struct packed {
    mv_t         mv;
    logic [15:0] oh;
    logic        base;
    logic        found;
    logic        zero;
  } vec_pl_t;

  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/particle_motion_sample_visibility_unit.sv @@
// Top level of the particle motion sample unit with observer visibility check.
//
// Usage: push one particle word (pose plus two normal samples) on in_word with
// in_push while in_full is low; one result word per particle appears on
// out_word while out_empty is low and is taken with out_pop. Results come out
// in input order. The configuration port writes register cfg_idx with
// cfg_wdata when cfg_we is high; write only while no particle is in flight.
// Throughput is one word per cycle while out_pop keeps up. Each particle passes
// a five stage front (distance, deviation select, step length), a queue of
// Q_DEPTH words, then the back pipeline with its rotation CORDIC, displacement
// product, range check, vectoring CORDIC for the bearing and the window test.
// The two CORDIC pipelines make up most of its depth. When out_pop stays low
// the back pipeline holds, the queue fills, then the front holds and in_full
// rises. Synchronous reset empties every pipeline and the queue and loads the
// default configuration.
module particle_motion_sample_visibility_unit
  import pmsv_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int Q_DEPTH       = Q_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_word_t             in_word,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  obs_pose_t [NUM_OBS-1:0] obs_r;
  logic [15:0]             range_lim_r, view_width_r, sig_near_r, sig_far_r, sig_head_r;
  logic [31:0]             r2_r;
  logic [38:0]             far_thr_r;
  cfg_t                    cfg;

  logic      q_push, q_full, q_pop, q_empty;
  fwd_word_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_r        <= '0;
      range_lim_r  <= RANGE_LIM_RST;
      view_width_r <= VIEW_WIDTH_RST;
      sig_near_r   <= SIG_NEAR_RST;
      sig_far_r    <= SIG_FAR_RST;
      sig_head_r   <= SIG_HEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_OBS_ONE:   obs_r[0]     <= obs_pose_t'(cfg_wdata);
        CFG_OBS_TWO:   obs_r[1]     <= obs_pose_t'(cfg_wdata);
        CFG_OBS_THREE: obs_r[2]     <= obs_pose_t'(cfg_wdata);
        CFG_RANGE_LIM: range_lim_r  <= cfg_wdata[15:0];
        CFG_VIEW_W:    view_width_r <= cfg_wdata[15:0];
        CFG_SIG_NEAR:  sig_near_r   <= cfg_wdata[15:0];
        CFG_SIG_FAR:   sig_far_r    <= cfg_wdata[15:0];
        CFG_SIG_HEAD:  sig_head_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // squared range and 81 * squared range, kept up to date from the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_r      <= R2_RST;
      far_thr_r <= FAR_THR_RST;
    end else begin
      r2_r      <= range_lim_r * range_lim_r;
      far_thr_r <= ({7'd0, r2_r} << 6) + ({7'd0, r2_r} << 4) + {7'd0, r2_r};
    end
  end

  always_comb begin
    cfg.obs        = obs_r;
    cfg.view_width = view_width_r;
    cfg.sig_near   = sig_near_r;
    cfg.sig_far    = sig_far_r;
    cfg.sig_head   = sig_head_r;
    cfg.r2         = r2_r;
    cfg.far_thr    = far_thr_r;
  end

  pmsv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .q_push  (q_push),
    .q_word  (q_din),
    .q_full  (q_full)
  );

  pmsv_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  pmsv_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_word    (q_dout),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

@@ hdl/pmsv_cordic.sv @@
// Pipelined CORDIC, one micro-rotation per stage, rotation or vectoring mode.
module pmsv_cordic
  import pmsv_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter bit VECTOR = 1'b0,
  parameter int PW     = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  input  logic [PW-1:0]        in_pl,
  output logic                 out_v,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z,
  output logic [PW-1:0]        out_pl
);

  logic                 v_r  [STAGES];
  logic signed [CW-1:0] x_r  [STAGES];
  logic signed [CW-1:0] y_r  [STAGES];
  logic signed [CW-1:0] z_r  [STAGES];
  logic [PW-1:0]        pl_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                 vi;
    logic signed [CW-1:0] xi, yi, zi, at;
    logic [PW-1:0]        pli;
    logic                 dir;

    if (k == 0) begin : g_first
      assign vi  = in_v;
      assign xi  = in_x;
      assign yi  = in_y;
      assign zi  = in_z;
      assign pli = in_pl;
    end else begin : g_rest
      assign vi  = v_r[k-1];
      assign xi  = x_r[k-1];
      assign yi  = y_r[k-1];
      assign zi  = z_r[k-1];
      assign pli = pl_r[k-1];
    end

    assign at  = $signed({2'b00, atan_q30(k)});
    // vectoring drives y to zero, rotation drives z to zero
    assign dir = VECTOR ? yi[CW-1] : !zi[CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pl_r[k] <= pli;
        if (dir) begin
          x_r[k] <= xi - (yi >>> k);
          y_r[k] <= yi + (xi >>> k);
          z_r[k] <= zi - at;
        end else begin
          x_r[k] <= xi + (yi >>> k);
          y_r[k] <= yi - (xi >>> k);
          z_r[k] <= zi + at;
        end
      end
    end
  end

  assign out_v  = v_r[STAGES-1];
  assign out_x  = x_r[STAGES-1];
  assign out_y  = y_r[STAGES-1];
  assign out_z  = z_r[STAGES-1];
  assign out_pl = pl_r[STAGES-1];

endmodule

@@ hdl/pmsv_front.sv @@
// Front pipeline: nearest-observer test, deviation select, turn and step length.
module pmsv_front
  import pmsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_push,
  input  in_word_t  in_word,
  output logic      in_full,
  output logic      q_push,
  output fwd_word_t q_word,
  input  logic      q_full
);

  logic adv;

  logic     s1_v_r;
  in_word_t s1_r;

  logic               s2_v_r;
  logic signed [15:0] s2_px_r, s2_py_r, s2_nr_r;
  logic [15:0]        s2_h_r;
  logic [31:0]        s2_sqx_r [NUM_OBS];
  logic [31:0]        s2_sqy_r [NUM_OBS];
  logic signed [32:0] s2_tp_r;

  logic               s3_v_r;
  logic signed [15:0] s3_px_r, s3_py_r, s3_nr_r;
  logic [15:0]        s3_h_r, s3_nhd_r;
  logic [32:0]        s3_dmin_r;

  logic               s4_v_r;
  logic signed [15:0] s4_px_r, s4_py_r, s4_nr_r;
  logic [15:0]        s4_h_r, s4_nhd_r, s4_sig_r;

  logic      s5_v_r;
  fwd_word_t s5_r;

  logic signed [16:0] dx_c [NUM_OBS];
  logic signed [16:0] dy_c [NUM_OBS];
  logic signed [33:0] px2_c [NUM_OBS];
  logic signed [33:0] py2_c [NUM_OBS];
  logic [32:0]        d2_c [NUM_OBS];
  logic [32:0]        dmin_c;
  logic signed [32:0] tsum_c;
  logic [39:0]        d100_c;

  assign adv     = !(s5_v_r && q_full);
  assign in_full = !adv;
  assign q_push  = s5_v_r && !q_full;
  assign q_word  = s5_r;

  always_comb begin
    for (int i = 0; i < NUM_OBS; i++) begin
      dx_c[i]  = {s1_r.pos_x[15], s1_r.pos_x} - {cfg.obs[i].x[15], cfg.obs[i].x};
      dy_c[i]  = {s1_r.pos_y[15], s1_r.pos_y} - {cfg.obs[i].y[15], cfg.obs[i].y};
      px2_c[i] = dx_c[i] * dx_c[i];
      py2_c[i] = dy_c[i] * dy_c[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_OBS; i++) begin
      d2_c[i] = {1'b0, s2_sqx_r[i]} + {1'b0, s2_sqy_r[i]};
    end
    dmin_c = d2_c[0];
    for (int i = 1; i < NUM_OBS; i++) begin
      if (d2_c[i] < dmin_c) begin
        dmin_c = d2_c[i];
      end
    end
    tsum_c = s2_tp_r + 33'sd2048;
  end

  // 100 * dmin by shift and add
  assign d100_c = ({7'd0, s3_dmin_r} << 6) + ({7'd0, s3_dmin_r} << 5)
                + ({7'd0, s3_dmin_r} << 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_push;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_word;

      s2_px_r <= s1_r.pos_x;
      s2_py_r <= s1_r.pos_y;
      s2_h_r  <= s1_r.heading;
      s2_nr_r <= s1_r.noise_range;
      for (int i = 0; i < NUM_OBS; i++) begin
        s2_sqx_r[i] <= px2_c[i][31:0];
        s2_sqy_r[i] <= py2_c[i][31:0];
      end
      s2_tp_r <= $signed({1'b0, cfg.sig_head}) * $signed(s1_r.noise_heading);

      s3_px_r   <= s2_px_r;
      s3_py_r   <= s2_py_r;
      s3_nr_r   <= s2_nr_r;
      s3_h_r    <= s2_h_r;
      s3_nhd_r  <= s2_h_r + tsum_c[27:12];
      s3_dmin_r <= dmin_c;

      s4_px_r  <= s3_px_r;
      s4_py_r  <= s3_py_r;
      s4_nr_r  <= s3_nr_r;
      s4_h_r   <= s3_h_r;
      s4_nhd_r <= s3_nhd_r;
      s4_sig_r <= (d100_c > {1'b0, cfg.far_thr}) ? cfg.sig_far : cfg.sig_near;

      s5_r.px  <= s4_px_r;
      s5_r.py  <= s4_py_r;
      s5_r.h   <= s4_h_r;
      s5_r.nhd <= s4_nhd_r;
      s5_r.r   <= $signed({1'b0, s4_sig_r}) * $signed(s4_nr_r);
    end
  end

endmodule

@@ hdl/pmsv_fifo.sv @@
// Short word queue between the front and back pipelines.
module pmsv_fifo
  import pmsv_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fwd_word_t din,
  output logic      full,
  input  logic      pop,
  output fwd_word_t dout,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  fwd_word_t         mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]   cnt_r;

  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a lone write");
`endif

endmodule

@@ hdl/pmsv_back.sv @@
// Back pipeline: rotate the step, place the new point, check visibility, pick the pose.
module pmsv_back
  import pmsv_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  output logic      q_pop,
  input  fwd_word_t q_word,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  localparam int RPW = $bits(rot_pl_t);
  localparam int VPW = $bits(vec_pl_t);

  logic adv;

  // rotation setup
  logic                 b1_v_r;
  logic signed [CW-1:0] b1_z_r;
  rot_pl_t              b1_pl_r;

  logic [15:0]          hs_c, hf_c, tm_c;
  logic                 neg_c;
  logic [48:0]          zp_c;

  logic                 rot_v;
  logic signed [CW-1:0] rot_x, rot_y;
  logic [RPW-1:0]       rot_pl_raw;
  rot_pl_t              rot_pl;

  // displacement products
  logic               p1_v_r;
  logic signed [50:0] p1_xh_r, p1_yh_r;
  logic signed [51:0] p1_xl_r, p1_yl_r;
  rot_pl_t            p1_pl_r;

  logic               p2_v_r;
  logic signed [19:0] p2_dx_r, p2_dy_r;
  rot_pl_t            p2_pl_r;
  logic signed [69:0] fx_c, fy_c;

  logic p3_v_r;
  mv_t  p3_r;

  // observer range check
  logic               d1_v_r;
  logic signed [16:0] d1_dx_r [NUM_OBS];
  logic signed [16:0] d1_dy_r [NUM_OBS];
  logic [31:0]        d1_sqx_r [NUM_OBS];
  logic [31:0]        d1_sqy_r [NUM_OBS];
  mv_t                d1_mv_r;
  logic signed [16:0] odx_c [NUM_OBS];
  logic signed [16:0] ody_c [NUM_OBS];
  logic signed [33:0] ox2_c [NUM_OBS];
  logic signed [33:0] oy2_c [NUM_OBS];

  logic               d2_v_r;
  logic               d2_found_r;
  logic signed [16:0] d2_dx_r, d2_dy_r;
  logic [15:0]        d2_oh_r;
  mv_t                d2_mv_r;
  logic               fnd_c;
  logic signed [16:0] sdx_c, sdy_c;
  logic [15:0]        soh_c;
  logic [32:0]        od2_c;

  logic                 d3_v_r;
  logic signed [CW-1:0] d3_x_r, d3_y_r;
  vec_pl_t              d3_pl_r;
  logic signed [CW-1:0] vx0_c, vy0_c;

  logic                 vec_v;
  logic signed [CW-1:0] vec_z;
  logic [VPW-1:0]       vec_pl_raw;
  vec_pl_t              vec_pl;

  // angle to turns
  logic        t1_v_r;
  logic        t1_neg_r;
  logic [45:0] t1_hp_r, t1_lp_r;
  vec_pl_t     t1_pl_r;
  logic [CW-1:0] zm_c;

  logic        t2_v_r;
  logic        t2_neg_r;
  logic [16:0] t2_tv_r;
  vec_pl_t     t2_pl_r;
  logic [63:0] ts_c;

  logic [15:0] stv_c, bear_c, wd_c;
  logic        keep_c;

  logic      out_v_r;
  out_word_t out_r;

  assign adv       = !out_v_r || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !out_v_r;
  assign out_word  = out_r;

  // fold quadrant: headings in the back half are flipped and the result negated
  always_comb begin
    hs_c  = q_word.nhd + 16'h4000;
    neg_c = hs_c[15];
    hf_c  = neg_c ? (q_word.nhd ^ 16'h8000) : q_word.nhd;
    tm_c  = hf_c[15] ? (~hf_c + 16'd1) : hf_c;
    zp_c  = 49'(tm_c) * 49'(K_RAD) + 49'd32768;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_z_r <= hf_c[15] ? -$signed({3'b000, zp_c[46:16]}) : $signed({3'b000, zp_c[46:16]});
      b1_pl_r.px  <= q_word.px;
      b1_pl_r.py  <= q_word.py;
      b1_pl_r.h   <= q_word.h;
      b1_pl_r.nhd <= q_word.nhd;
      b1_pl_r.rn  <= neg_c ? -$signed({q_word.r[32], q_word.r})
                           : $signed({q_word.r[32], q_word.r});
    end
  end

  pmsv_cordic #(
    .STAGES (CORDIC_STAGES),
    .VECTOR (1'b0),
    .PW     (RPW)
  ) u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (b1_v_r),
    .in_x   (CORDIC_X0),
    .in_y   ('0),
    .in_z   (b1_z_r),
    .in_pl  (b1_pl_r),
    .out_v  (rot_v),
    .out_x  (rot_x),
    .out_y  (rot_y),
    .out_z  (),
    .out_pl (rot_pl_raw)
  );

  assign rot_pl = rot_pl_t'(rot_pl_raw);

  // step times cosine/sine, split into high and low partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_xh_r <= $signed(rot_pl.rn) * $signed(rot_x[CW-1:17]);
      p1_xl_r <= $signed(rot_pl.rn) * $signed({1'b0, rot_x[16:0]});
      p1_yh_r <= $signed(rot_pl.rn) * $signed(rot_y[CW-1:17]);
      p1_yl_r <= $signed(rot_pl.rn) * $signed({1'b0, rot_y[16:0]});
      p1_pl_r <= rot_pl;
    end
  end

  always_comb begin
    fx_c = (70'(p1_xh_r) <<< 17) + 70'(p1_xl_r) + 70'sd562949953421312;
    fy_c = (70'(p1_yh_r) <<< 17) + 70'(p1_yl_r) + 70'sd562949953421312;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_dx_r <= fx_c[69:50];
      p2_dy_r <= fy_c[69:50];
      p2_pl_r <= p1_pl_r;

      p3_r.px  <= p2_pl_r.px;
      p3_r.py  <= p2_pl_r.py;
      p3_r.h   <= p2_pl_r.h;
      p3_r.nhd <= p2_pl_r.nhd;
      p3_r.nx  <= sat16(21'(p2_pl_r.px) + 21'(p2_dx_r));
      p3_r.ny  <= sat16(21'(p2_pl_r.py) + 21'(p2_dy_r));
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_OBS; i++) begin
      odx_c[i] = {p3_r.nx[15], p3_r.nx} - {cfg.obs[i].x[15], cfg.obs[i].x};
      ody_c[i] = {p3_r.ny[15], p3_r.ny} - {cfg.obs[i].y[15], cfg.obs[i].y};
      ox2_c[i] = odx_c[i] * odx_c[i];
      oy2_c[i] = ody_c[i] * ody_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_OBS; i++) begin
        d1_dx_r[i]  <= odx_c[i];
        d1_dy_r[i]  <= ody_c[i];
        d1_sqx_r[i] <= ox2_c[i][31:0];
        d1_sqy_r[i] <= oy2_c[i][31:0];
      end
      d1_mv_r <= p3_r;
    end
  end

  // first observer in range wins: scan from the last so the first overrides
  always_comb begin
    fnd_c = 1'b0;
    sdx_c = d1_dx_r[0];
    sdy_c = d1_dy_r[0];
    soh_c = cfg.obs[0].hd;
    od2_c = '0;
    for (int i = NUM_OBS - 1; i >= 0; i--) begin
      od2_c = {1'b0, d1_sqx_r[i]} + {1'b0, d1_sqy_r[i]};
      if (od2_c <= {1'b0, cfg.r2}) begin
        fnd_c = 1'b1;
        sdx_c = d1_dx_r[i];
        sdy_c = d1_dy_r[i];
        soh_c = cfg.obs[i].hd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_found_r <= fnd_c;
      d2_dx_r    <= sdx_c;
      d2_dy_r    <= sdy_c;
      d2_oh_r    <= soh_c;
      d2_mv_r    <= d1_mv_r;
    end
  end

  assign vx0_c = CW'($signed({d2_dx_r, 12'd0}));
  assign vy0_c = CW'($signed({d2_dy_r, 12'd0}));

  // left half plane: pre-rotate by a half turn
  always_ff @(posedge clk) begin
    if (adv) begin
      d3_x_r        <= d2_dx_r[16] ? -vx0_c : vx0_c;
      d3_y_r        <= d2_dx_r[16] ? -vy0_c : vy0_c;
      d3_pl_r.mv    <= d2_mv_r;
      d3_pl_r.oh    <= d2_oh_r;
      d3_pl_r.base  <= d2_dx_r[16];
      d3_pl_r.found <= d2_found_r;
      d3_pl_r.zero  <= (d2_dx_r == '0) && (d2_dy_r == '0);
    end
  end

  pmsv_cordic #(
    .STAGES (CORDIC_STAGES),
    .VECTOR (1'b1),
    .PW     (VPW)
  ) u_vec (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (d3_v_r),
    .in_x   (d3_x_r),
    .in_y   (d3_y_r),
    .in_z   ('0),
    .in_pl  (d3_pl_r),
    .out_v  (vec_v),
    .out_x  (),
    .out_y  (),
    .out_z  (vec_z),
    .out_pl (vec_pl_raw)
  );

  assign vec_pl = vec_pl_t'(vec_pl_raw);
  assign zm_c   = vec_z[CW-1] ? CW'(-vec_z) : CW'(vec_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_neg_r <= vec_z[CW-1];
      t1_hp_r  <= 46'(zm_c[31:16]) * 46'(K_TURN);
      t1_lp_r  <= 46'(zm_c[15:0]) * 46'(K_TURN);
      t1_pl_r  <= vec_pl;
    end
  end

  assign ts_c = (64'(t1_hp_r) << 16) + 64'(t1_lp_r) + 64'h0000_2000_0000_0000;

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_neg_r <= t1_neg_r;
      t2_tv_r  <= ts_c[62:46];
      t2_pl_r  <= t1_pl_r;
    end
  end

  // window test wraps modulo a turn
  always_comb begin
    stv_c  = t2_neg_r ? (~t2_tv_r[15:0] + 16'd1) : t2_tv_r[15:0];
    bear_c = t2_pl_r.zero ? 16'd0 : ({t2_pl_r.base, 15'd0} + stv_c);
    wd_c   = bear_c - t2_pl_r.oh + {1'b0, cfg.view_width[15:1]};
    keep_c = t2_pl_r.found && (wd_c <= cfg.view_width);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (keep_c) begin
        out_r.new_x       <= t2_pl_r.mv.nx;
        out_r.new_y       <= t2_pl_r.mv.ny;
        out_r.new_heading <= t2_pl_r.mv.nhd;
        out_r.moved       <= 1'b1;
      end else begin
        out_r.new_x       <= t2_pl_r.mv.px;
        out_r.new_y       <= t2_pl_r.mv.py;
        out_r.new_heading <= t2_pl_r.mv.h;
        out_r.moved       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      d1_v_r  <= 1'b0;
      d2_v_r  <= 1'b0;
      d3_v_r  <= 1'b0;
      t1_v_r  <= 1'b0;
      t2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= !q_empty;
      p1_v_r  <= rot_v;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      d1_v_r  <= p3_v_r;
      d2_v_r  <= d1_v_r;
      d3_v_r  <= d2_v_r;
      t1_v_r  <= vec_v;
      t2_v_r  <= t1_v_r;
      out_v_r <= t2_v_r;
    end
  end

endmodule

@@ dv/tb_particle_motion_sample_visibility_unit.sv @@
// Self-checking bench for the particle motion sample unit with visibility check.
module tb_particle_motion_sample_visibility_unit;
  import pmsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = 2 * CORDIC_STAGES_DEF + 15;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_push;
  in_word_t in_word;
  logic in_full;
  logic out_empty;
  logic out_pop;
  out_word_t out_word;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  particle_motion_sample_visibility_unit uut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_word(in_word), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // shadow of the register file
  logic [47:0] obs_pose [NUM_OBS];
  logic [15:0] rng_max, view_w, sig_near, sig_far, sig_head;

  out_word_t pose_q [$];
  int mismatches;
  longint cycles;
  bit calm;
  int hold_cycles;

  longint atan_tab [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void cordic_rotate(input logic [15:0] hd, output longint c,
                                        output longint s);
    logic [15:0] h;
    bit neg;
    longint t, z, x, y, nx;
    h = hd;
    neg = 0;
    x = 652032874;
    y = 0;
    if (((h + 16'h4000) & 16'hFFFF) >= 16'h8000) begin
      neg = 1;
      h = h ^ 16'h8000;
    end
    t = longint'($signed(h));
    z = ((t < 0 ? -t : t) * 64'd6746518852 + 32768) >>> 16;
    if (t < 0) z = -z;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_tab[i];
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_tab[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic [15:0] bearing_of(longint dx, longint dy);
    longint x, y, z, nx, tv, m;
    logic [15:0] base;
    if (dx == 0 && dy == 0) return 16'd0;
    x = dx * 4096;
    y = dy * 4096;
    z = 0;
    base = 0;
    if (x < 0) begin
      x = -x; y = -y; base = 16'h8000;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      if (y < 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_tab[i];
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_tab[i];
      end
      x = nx;
    end
    m = z < 0 ? -z : z;
    // product fits below 2^63 for the angles reachable here
    tv = (m * 683565276 + (longint'(1) << 45)) >>> 46;
    if (z < 0) tv = -tv;
    return 16'(longint'(base) + tv);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic out_word_t propagate_pose(in_word_t w);
    out_word_t res;
    longint px, py, ox[NUM_OBS], oy[NUM_OBS], dx, dy, d2, dmin, r2, r, turn, c, s, nx, ny;
    logic [15:0] nhd, sig, d;
    bit keep;
    px = w.pos_x;
    py = w.pos_y;
    r2 = longint'(rng_max) * rng_max;
    dmin = 0;
    keep = 0;
    for (int i = 0; i < NUM_OBS; i++) begin
      ox[i] = longint'($signed(obs_pose[i][47:32]));
      oy[i] = longint'($signed(obs_pose[i][31:16]));
      dx = px - ox[i];
      dy = py - oy[i];
      d2 = dx * dx + dy * dy;
      if (i == 0 || d2 < dmin) dmin = d2;
    end
    sig = (100 * dmin > 81 * r2) ? sig_far : sig_near;
    r = longint'(sig) * longint'(w.noise_range);
    turn = (longint'(sig_head) * longint'(w.noise_heading) + 2048) >>> 12;
    nhd = 16'(longint'(w.heading) + turn);
    cordic_rotate(nhd, c, s);
    // r*c stays below 2^62
    nx = clip16(px + ((r * c + (longint'(1) << 49)) >>> 50));
    ny = clip16(py + ((r * s + (longint'(1) << 49)) >>> 50));
    for (int i = 0; i < NUM_OBS; i++) begin
      dx = nx - ox[i];
      dy = ny - oy[i];
      if (dx * dx + dy * dy <= r2) begin
        d = bearing_of(dx, dy) - obs_pose[i][15:0] + (view_w >> 1);
        keep = d <= view_w;
        break;
      end
    end
    if (keep) begin
      res.new_x = 16'(nx); res.new_y = 16'(ny); res.new_heading = nhd; res.moved = 1'b1;
    end else begin
      res.new_x = w.pos_x; res.new_y = w.pos_y; res.new_heading = w.heading;
      res.moved = 1'b0;
    end
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: random pop, long hold-off on request
  initial begin
    out_pop = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_word);
        end else begin
          out_word_t e;
          e = pose_q.pop_front();
          if (out_word.new_x !== e.new_x || out_word.new_y !== e.new_y ||
              out_word.new_heading !== e.new_heading || out_word.moved !== e.moved) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp x=%0d y=%0d h=%0d m=%0b got x=%0d y=%0d h=%0d m=%0b",
                       e.new_x, e.new_y, e.new_heading, e.moved, out_word.new_x,
                       out_word.new_y, out_word.new_heading, out_word.moved);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm ? 1'b1 : ($urandom_range(99) >= 11);
      end
    end
  end

  // cfg_we drops again after each write, so each call makes a single update
  task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_OBS_ONE: obs_pose[0] = val;
      CFG_OBS_TWO: obs_pose[1] = val;
      CFG_OBS_THREE: obs_pose[2] = val;
      CFG_RANGE_LIM: rng_max = val[15:0];
      CFG_VIEW_W: view_w = val[15:0];
      CFG_SIG_NEAR: sig_near = val[15:0];
      CFG_SIG_FAR: sig_far = val[15:0];
      CFG_SIG_HEAD: sig_head = val[15:0];
      default: ;
    endcase
  endtask

  // called right after a posedge; leaves on the posedge that accepts the word
  task automatic push_particle(in_word_t w);
    while (!calm && $urandom_range(99) < 11) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    pose_q.push_back(propagate_pose(w));
  endtask

  task automatic drain;
    in_push <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  function automatic in_word_t rand_particle(int spread);
    in_word_t w;
    w = 80'({$urandom, $urandom, $urandom});
    if (spread > 0) begin
      w.pos_x = 16'($signed($urandom_range(2 * spread)) - spread);
      w.pos_y = 16'($signed($urandom_range(2 * spread)) - spread);
      w.noise_range = 16'($signed($urandom_range(16384)) - 8192);
      w.noise_heading = 16'($signed($urandom_range(16384)) - 8192);
    end
    return w;
  endfunction

  task automatic test_directed;
    in_word_t w;
    logic [15:0] xs [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0100, 16'hFF00, 16'h0001};
    for (int i = 0; i < 6; i++) begin
      w.pos_x = xs[i]; w.pos_y = xs[5 - i]; w.heading = xs[i];
      w.noise_range = xs[(i + 1) % 6]; w.noise_heading = xs[(i + 3) % 6];
      push_particle(w);
    end
    // particle on the observer, no motion
    w = '0;
    push_particle(w);
    // step from near the positive x and negative y limits
    w.pos_x = 16'sh7F00; w.pos_y = 16'sh8100; w.heading = 16'h2000;
    w.noise_range = 16'sh7FFF; w.noise_heading = 16'sh8000;
    push_particle(w);
    drain();
  endtask

  task automatic run_phase(int n, int spread);
    for (int i = 0; i < n; i++) push_particle(rand_particle(spread));
    drain();
  endtask

  task automatic test_config_sweep;
    // window across zero, wide sigmas
    write_reg(CFG_OBS_ONE, {16'sh0100, 16'shFF00, 16'hFF00});
    write_reg(CFG_OBS_TWO, {16'shFC00, 16'sh0400, 16'h8000});
    write_reg(CFG_OBS_THREE, {16'sh0800, 16'sh0800, 16'h4000});
    write_reg(CFG_VIEW_W, 48'h8000);
    write_reg(CFG_SIG_NEAR, 48'hFFFF);
    write_reg(CFG_SIG_FAR, 48'h0000);
    write_reg(CFG_SIG_HEAD, 48'hFFFF);
    run_phase(300, 2048);
    write_reg(CFG_RANGE_LIM, 48'h0000);
    write_reg(CFG_VIEW_W, 48'h0000);
    run_phase(100, 512);
    write_reg(CFG_RANGE_LIM, 48'hFFFF);
    write_reg(CFG_VIEW_W, 48'hFFFF);
    write_reg(CFG_SIG_HEAD, 48'h0000);
    run_phase(150, 0);
    write_reg(CFG_RANGE_LIM, 48'h0300);
    write_reg(CFG_SIG_FAR, 48'hFFFF);
    write_reg(CFG_SIG_NEAR, 48'h0100);
    write_reg(CFG_SIG_HEAD, 48'h2AAB);
    write_reg(CFG_VIEW_W, 48'h3000);
    run_phase(300, 2048);
  endtask

  task automatic test_random_configs;
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 3; k++)
        write_reg(cfg_idx_t'(k), {16'($signed($urandom_range(4096)) - 2048),
                                  16'($signed($urandom_range(4096)) - 2048), 16'($urandom)});
      write_reg(CFG_RANGE_LIM, 48'($urandom_range(512, 4096)));
      write_reg(CFG_VIEW_W, 48'(16'($urandom)));
      write_reg(CFG_SIG_NEAR, 48'(16'($urandom)));
      write_reg(CFG_SIG_FAR, 48'(16'($urandom)));
      write_reg(CFG_SIG_HEAD, 48'(16'($urandom)));
      calm = (p == 2);
      run_phase(120, p == 5 ? 0 : 3000);
    end
    calm = 0;
  endtask

  task automatic test_backpressure;
    hold_cycles = 200;
    run_phase(100, 1024);
  endtask

  initial begin
    rst_n = 0;
    in_push = 0;
    in_word = '0;
    cfg_we = 0;
    cfg_idx = CFG_OBS_ONE;
    cfg_wdata = '0;
    mismatches = 0;
    calm = 0;
    hold_cycles = 0;
    for (int i = 0; i < NUM_OBS; i++) obs_pose[i] = '0;
    rng_max = RANGE_LIM_RST;
    view_w = VIEW_WIDTH_RST;
    sig_near = SIG_NEAR_RST;
    sig_far = SIG_FAR_RST;
    sig_head = SIG_HEAD_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    run_phase(150, 1024);
    test_backpressure();
    test_config_sweep();
    test_random_configs();
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
